>>> hdl/whc_pkg.sv
package whc_pkg;

  typedef enum logic [1:0] {
    MODE_OR  = 2'd0,
    MODE_AND = 2'd1,
    MODE_XOR = 2'd2
  } mode_t;

  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam int MODE_W   = 2;
  localparam int LOGLEN_W = 3;
  localparam int CFG_W    = 3;
  localparam int RES_W    = 44;
  localparam int IDX_W    = 6;

  localparam logic [0:0] REG_MODE    = 1'b0;
  localparam logic [0:0] REG_LOG_LEN = 1'b1;

  localparam mode_t                MODE_RST   = MODE_XOR;
  localparam logic [LOGLEN_W-1:0]  LOGLEN_RST = 3'd2;

  localparam longint SAT_LIMIT = 64'sd4398046511104;

endpackage

>>> hdl/walsh_hadamard_convolution_top.sv
// Walsh-Hadamard convolution of two vectors of length n = 2**lg, where lg is the log_length
// register clamped to LOG_MAX_LEN. Element pairs are loaded one per cycle in index order; the
// pair that completes the set starts the run: forward butterflies on store A, then on store B,
// n pointwise products, inverse butterflies on A, then n results drained in index order with
// the last one flagged. Every butterfly goes through one shared add/subtract unit and the
// stores' single write port, in three steps (read, write low, write high); each product is
// read and then written back, and each result is read, loaded and held until it is taken.
// The input is not ready from the completing pair until the last result is taken. A mode
// write of 3 is ignored; results saturate to +/- 2**42. The stores need no clearing after
// reset.
module walsh_hadamard_convolution_top #(
  parameter int LOG_MAX_LEN = 6,
  parameter int ELEM_WIDTH  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [0:0]                              cfg_index,
  input  logic [whc_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [ELEM_WIDTH-1:0]            in_a_elem,
  input  logic signed [ELEM_WIDTH-1:0]            in_b_elem,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [whc_pkg::RES_W-1:0]        out_result_value,
  output logic [whc_pkg::IDX_W-1:0]               out_result_index,
  output logic                                    out_is_last
);

  localparam int MAX_LEN = 1 << LOG_MAX_LEN;
  localparam int ADDR_W  = LOG_MAX_LEN;
  localparam int AW      = ELEM_WIDTH + LOG_MAX_LEN;
  localparam int PW      = 2 * AW + LOG_MAX_LEN;
  localparam int LGW     = $clog2(LOG_MAX_LEN + 1);
  localparam int CNTW    = LOG_MAX_LEN + 1;
  localparam int RESW    = whc_pkg::RES_W;
  localparam int IDXW    = whc_pkg::IDX_W;
  localparam int SW      = (PW > RESW) ? PW : RESW;

  typedef enum logic [3:0] {
    S_LOAD,
    S_BF_RD,
    S_BF_W0,
    S_BF_W1,
    S_MUL_RD,
    S_MUL_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } state_t;

  typedef enum logic [1:0] {
    P_FWD_A,
    P_FWD_B,
    P_INV_A
  } pass_t;

  state_t                 state_r;
  pass_t                  pass_r;
  whc_pkg::mode_t         mode_r;
  logic [whc_pkg::LOGLEN_W-1:0] loglen_r;
  logic [CNTW-1:0]        load_cnt_r;
  logic [LGW-1:0]         stage_r;
  logic [ADDR_W-1:0]      pair_r;
  logic [ADDR_W-1:0]      elem_r;
  logic                   out_valid_r;
  logic signed [RESW-1:0] out_value_r;
  logic [IDXW-1:0]        out_index_r;
  logic                   out_last_r;

  logic [PW-1:0]          mem_a [MAX_LEN];
  logic [AW-1:0]          mem_b [MAX_LEN];
  logic [PW-1:0]          a_rd0_r, a_rd1_r;
  logic [AW-1:0]          b_rd0_r, b_rd1_r;

  logic [LGW-1:0]         lg_c;
  logic [CNTW-1:0]        n_c;
  logic [CNTW-1:0]        load_next_c;
  logic                   fire_c;
  logic [ADDR_W-1:0]      half_m1_c, last_elem_c;
  logic [ADDR_W-1:0]      bit_c, lowm_c, low_addr_c, high_addr_c;
  logic                   stage_last_c, pass_last_c, inv_c;

  logic                   a_we, b_we;
  logic [ADDR_W-1:0]      a_wa, b_wa, rd_addr0_c;
  logic [PW-1:0]          a_wd;
  logic [AW-1:0]          b_wd;

  logic [PW-1:0]          x_c, y_c, opa_c, opb_c, bf_res_c;
  logic                   sub_c;
  logic [PW:0]            wide_c;
  logic signed [2*AW-1:0] prod_c;
  logic signed [SW-1:0]   val_c, lim_c, sat_c;

  // length and pair addressing
  always_comb begin
    lg_c        = (int'(loglen_r) > LOG_MAX_LEN) ? LGW'(LOG_MAX_LEN) : LGW'(loglen_r);
    n_c         = CNTW'(1) << lg_c;
    load_next_c = load_cnt_r + CNTW'(1);
    fire_c      = (load_next_c >= n_c);
    half_m1_c   = ADDR_W'((n_c >> 1) - CNTW'(1));
    last_elem_c = ADDR_W'(n_c - CNTW'(1));
    bit_c       = ADDR_W'(1) << stage_r;
    lowm_c      = bit_c - ADDR_W'(1);
    low_addr_c  = ((pair_r & ~lowm_c) << 1) | (pair_r & lowm_c);
    high_addr_c = low_addr_c | bit_c;
    stage_last_c = (pair_r == half_m1_c);
    pass_last_c  = stage_last_c && (stage_r == lg_c - LGW'(1));
    inv_c        = (pass_r == P_INV_A);
    rd_addr0_c   = (state_r == S_BF_RD || state_r == S_BF_W0) ? low_addr_c : elem_r;
  end

  // shared add/subtract unit
  always_comb begin
    x_c   = (pass_r == P_FWD_B) ? PW'($signed(b_rd0_r)) : a_rd0_r;
    y_c   = (pass_r == P_FWD_B) ? PW'($signed(b_rd1_r)) : a_rd1_r;
    opa_c = x_c;
    opb_c = y_c;
    sub_c = 1'b0;
    if (state_r == S_BF_W1) begin
      if (mode_r == whc_pkg::MODE_OR) begin
        if (inv_c) begin
          opa_c = y_c;
          opb_c = x_c;
          sub_c = 1'b1;
        end
      end else begin
        sub_c = 1'b1;
      end
    end else begin
      sub_c = inv_c && (mode_r == whc_pkg::MODE_AND);
    end
    wide_c   = sub_c ? ({opa_c[PW-1], opa_c} - {opb_c[PW-1], opb_c})
                     : ({opa_c[PW-1], opa_c} + {opb_c[PW-1], opb_c});
    bf_res_c = (inv_c && (mode_r == whc_pkg::MODE_XOR)) ? wide_c[PW:1] : wide_c[PW-1:0];
  end

  assign prod_c = $signed(a_rd0_r[AW-1:0]) * $signed(b_rd0_r);

  // output saturation
  always_comb begin
    val_c = SW'($signed(a_rd0_r));
    lim_c = SW'(whc_pkg::SAT_LIMIT);
    priority if (val_c > lim_c) begin
      sat_c = lim_c;
    end else if (val_c < -lim_c) begin
      sat_c = -lim_c;
    end else begin
      sat_c = val_c;
    end
  end

  // store write port control
  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    a_wa = low_addr_c;
    b_wa = low_addr_c;
    a_wd = bf_res_c;
    b_wd = bf_res_c[AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        a_we = in_valid;
        b_we = in_valid;
        a_wa = load_cnt_r[ADDR_W-1:0];
        b_wa = load_cnt_r[ADDR_W-1:0];
        a_wd = PW'(in_a_elem);
        b_wd = AW'(in_b_elem);
      end
      S_BF_W0: begin
        a_we = (mode_r != whc_pkg::MODE_OR) && (pass_r != P_FWD_B);
        b_we = (mode_r != whc_pkg::MODE_OR) && (pass_r == P_FWD_B);
      end
      S_BF_W1: begin
        a_we = (mode_r != whc_pkg::MODE_AND) && (pass_r != P_FWD_B);
        b_we = (mode_r != whc_pkg::MODE_AND) && (pass_r == P_FWD_B);
        a_wa = high_addr_c;
        b_wa = high_addr_c;
      end
      S_MUL_WR: begin
        a_we = 1'b1;
        a_wa = elem_r;
        a_wd = PW'(prod_c);
      end
      default: begin
        a_we = 1'b0;
        b_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[a_wa] <= a_wd;
    end
    a_rd0_r <= mem_a[rd_addr0_c];
    a_rd1_r <= mem_a[high_addr_c];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[b_wa] <= b_wd;
    end
    b_rd0_r <= mem_b[rd_addr0_c];
    b_rd1_r <= mem_b[high_addr_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      pass_r      <= P_FWD_A;
      mode_r      <= whc_pkg::MODE_RST;
      loglen_r    <= whc_pkg::LOGLEN_RST;
      load_cnt_r  <= '0;
      stage_r     <= '0;
      pair_r      <= '0;
      elem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          whc_pkg::REG_MODE: begin
            if (cfg_data[whc_pkg::MODE_W-1:0] != whc_pkg::MODE_RESERVED) begin
              mode_r <= whc_pkg::mode_t'(cfg_data[whc_pkg::MODE_W-1:0]);
            end
          end
          whc_pkg::REG_LOG_LEN: begin
            loglen_r <= cfg_data[whc_pkg::LOGLEN_W-1:0];
          end
        endcase
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (fire_c) begin
              load_cnt_r <= '0;
              stage_r    <= '0;
              pair_r     <= '0;
              elem_r     <= '0;
              pass_r     <= P_FWD_A;
              state_r    <= (lg_c == '0) ? S_MUL_RD : S_BF_RD;
            end else begin
              load_cnt_r <= load_next_c;
            end
          end
        end
        S_BF_RD: begin
          state_r <= S_BF_W0;
        end
        S_BF_W0: begin
          state_r <= S_BF_W1;
        end
        S_BF_W1: begin
          state_r <= S_BF_RD;
          if (!stage_last_c) begin
            pair_r <= pair_r + ADDR_W'(1);
          end else begin
            pair_r <= '0;
            if (!pass_last_c) begin
              stage_r <= stage_r + LGW'(1);
            end else begin
              stage_r <= '0;
              unique case (pass_r)
                P_FWD_A: begin
                  pass_r <= P_FWD_B;
                end
                P_FWD_B: begin
                  state_r <= S_MUL_RD;
                end
                P_INV_A: begin
                  state_r <= S_OUT_RD;
                end
              endcase
            end
          end
        end
        S_MUL_RD: begin
          state_r <= S_MUL_WR;
        end
        S_MUL_WR: begin
          if (elem_r == last_elem_c) begin
            elem_r  <= '0;
            pass_r  <= P_INV_A;
            state_r <= (lg_c == '0) ? S_OUT_RD : S_BF_RD;
          end else begin
            elem_r  <= elem_r + ADDR_W'(1);
            state_r <= S_MUL_RD;
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          out_value_r <= RESW'(sat_c);
          out_index_r <= IDXW'(elem_r);
          out_last_r  <= (elem_r == last_elem_c);
          state_r     <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              elem_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              elem_r  <= elem_r + ADDR_W'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_is_last      = out_last_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_is_last) |=> in_ready)
    else $error("input not ready after last result");

  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (in_ready || state_r == S_BF_RD || state_r == S_MUL_RD))
    else $error("bad state after loading an item");

endmodule
